// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the separation test core.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// ===== rtl/stst_pkg.sv =====
// Shared constants for the sphere-triangle separation test core.
// No dependencies; used by stst_mul and the top level.
`default_nettype none
package stst_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int RADIUS_BITS    = 15;
	// limb width of the partial-product multiplier
	localparam int MUL_LIMB       = 24;
	// cycles from multiplier operands to registered product
	localparam int MUL_LAT        = 4;
endpackage
`default_nettype wire

// ===== rtl/stst_mul.sv =====
// Pipelined exact signed multiplier built from unsigned limb products.
// Depends on stst_pkg; one product per cycle.
`default_nettype none
module stst_mul import stst_pkg::*; #(
	parameter int AW = 16,
	parameter int BW = 16
) (
	input  logic                     clk,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p
);
	localparam int NA = (AW + MUL_LIMB - 1) / MUL_LIMB;
	localparam int NB = (BW + MUL_LIMB - 1) / MUL_LIMB;
	localparam int MA = NA * MUL_LIMB;
	localparam int MB = NB * MUL_LIMB;
	localparam int PW = MA + MB;

	logic [AW-1:0]           abs_a;
	logic [BW-1:0]           abs_b;
	logic [MA-1:0]           mag_a_s1;
	logic [MB-1:0]           mag_b_s1;
	logic                    neg_s1, neg_s2, neg_s3;
	logic [2*MUL_LIMB-1:0]   pp_s2 [NA][NB];
	logic [PW-1:0]           sum_c;
	logic [PW-1:0]           sum_s3;

	// take magnitudes, remember the product sign
	assign abs_a = a[AW-1] ? AW'(-a) : AW'(a);
	assign abs_b = b[BW-1] ? BW'(-b) : BW'(b);

	// align and add the limb products
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum_c = sum_c + (PW'(pp_s2[i][j]) << (MUL_LIMB * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_a_s1 <= MA'(abs_a);
		mag_b_s1 <= MB'(abs_b);
		neg_s1   <= a[AW-1] ^ b[BW-1];
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s2[i][j] <= mag_a_s1[i*MUL_LIMB +: MUL_LIMB]
					* mag_b_s1[j*MUL_LIMB +: MUL_LIMB];
			end
		end
		neg_s2 <= neg_s1;
		sum_s3 <= sum_c;
		neg_s3 <= neg_s2;
		p      <= neg_s3 ? (AW+BW)'(PW'(0) - sum_s3) : (AW+BW)'(sum_s3);
	end
endmodule
`default_nettype wire

// ===== rtl/sphere_triangle_separation_test_core.sv =====
// Seven-axis sphere/triangle separation test, exact integer pipeline.
// Depends on stst_pkg, stst_mul and assert_macros.svh.
//
// Usage:
//   Request channel: drive the twelve coordinates and raise start; the
//   request is taken at every clock edge with start high, since busy stays
//   low. A new request may enter every cycle.
//   Result channel: done is high for one cycle with separated valid; the
//   receiver cannot hold results off and none is needed.
//   Throughput: one request per cycle. The pipeline is made of three
//   multiplier levels (stst_mul) and the add, compare and merge stages
//   between them.
//   Configuration: sphere_radius_we writes the radius; its square is
//   registered at the write. Write it only while no request is in flight.
//   Reset: clears the valid chain and the radius; no result is produced
//   for requests that were in flight.
//   Results leave in request order.
`default_nettype none
module sphere_triangle_separation_test_core import stst_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_BITS-1:0]  vert0_x,
	input  logic signed [COORD_BITS-1:0]  vert0_y,
	input  logic signed [COORD_BITS-1:0]  vert0_z,
	input  logic signed [COORD_BITS-1:0]  vert1_x,
	input  logic signed [COORD_BITS-1:0]  vert1_y,
	input  logic signed [COORD_BITS-1:0]  vert1_z,
	input  logic signed [COORD_BITS-1:0]  vert2_x,
	input  logic signed [COORD_BITS-1:0]  vert2_y,
	input  logic signed [COORD_BITS-1:0]  vert2_z,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic signed [COORD_BITS-1:0]  center_z,
	input  logic                          sphere_radius_we,
	input  logic [RADIUS_BITS-1:0]        sphere_radius_wdata,
	output logic                          done,
	output logic                          separated
);
	`include "assert_macros.svh"

	localparam int C   = COORD_BITS + 1;
	localparam int R   = RADIUS_BITS;
	localparam int LAT = 19;
	localparam int CA  = 6*C + 14;
	localparam int CB  = 2*R + 4*C + 10;
	localparam int CW  = (CA > CB) ? CA : CB;

	logic [2*R-1:0]           rr_q;
	logic signed [2*R:0]      rr_sg;
	logic [LAT:1]             vld_s;

	logic signed [COORD_BITS-1:0] vin [3][3];
	logic signed [COORD_BITS-1:0] ctr [3];

	logic signed [C-1:0]      p_s  [1:8][3][3];
	logic signed [C:0]        e_s  [2:8][3][3];

	logic signed [2*C+1:0]    mca  [3];
	logic signed [2*C+1:0]    mcb  [3];
	logic signed [2*C-1:0]    msq  [3][3];
	logic signed [2*C-1:0]    mx   [3][3];
	logic signed [2*C+1:0]    mee  [3][3];

	logic signed [2*C+2:0]    v_s7  [3];
	logic signed [2*C+2:0]    v_s8  [3];
	logic signed [2*C+1:0]    sq_s7 [3];
	logic signed [2*C+1:0]    x_s7  [3];
	logic signed [2*C+3:0]    ee_s  [7:13][3];
	logic signed [2*C+2:0]    d_s8  [3];
	logic [2:0]               vtx_s [8:18];
	logic [2:0]               vtx_c;

	logic signed [3*C+2:0]    mav  [3];
	logic signed [4*C+5:0]    mvv  [3];
	logic signed [3*C+3:0]    mpee [3][3];
	logic signed [3*C+3:0]    med  [3][3];
	logic signed [3*C+3:0]    moee [3][3];
	logic signed [2*R+2*C+4:0] mrree [3];

	logic signed [3*C+4:0]    f_s13;
	logic signed [4*C+7:0]    e_s13;
	logic signed [3*C+4:0]    q_s13  [3][3];
	logic signed [3*C+5:0]    qo_s13 [3][3];
	logic signed [2*R+2*C+4:0] rree_s13 [3];

	logic signed [6*C+9:0]    mff;
	logic signed [2*R+4*C+8:0] mre;
	logic signed [6*C+9:0]    mqq  [3][3];
	logic signed [6*C+10:0]   mqqo [3][3];
	logic signed [2*R+4*C+8:0] mr3 [3];

	logic                     plane_s18;
	logic signed [CW-1:0]     qq_s18  [3];
	logic signed [CW-1:0]     qqo_s18 [3];
	logic signed [2*R+4*C+8:0] r3_s18 [3];
	logic [2:0]               edge_c;
	logic                     sep_s19;

	assign busy      = 1'b0;
	assign done      = vld_s[LAT];
	assign separated = sep_s19;
	assign rr_sg     = $signed({1'b0, rr_q});

	assign vin[0] = '{vert0_x, vert0_y, vert0_z};
	assign vin[1] = '{vert1_x, vert1_y, vert1_z};
	assign vin[2] = '{vert2_x, vert2_y, vert2_z};
	assign ctr    = '{center_x, center_y, center_z};

	// hold the squared radius; advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q  <= '0;
			vld_s <= '0;
		end else begin
			if (sphere_radius_we) begin
				rr_q <= (2*R)'(sphere_radius_wdata) * (2*R)'(sphere_radius_wdata);
			end
			vld_s <= {vld_s[LAT-1:1], start};
		end
	end

	// s1: move the centre to the origin; s2: edge vectors
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				p_s[1][k][i] <= C'(vin[k][i]) - C'(ctr[i]);
				e_s[2][k][i] <= (C+1)'(p_s[1][(k+1)%3][i]) - (C+1)'(p_s[1][k][i]);
			end
		end
		for (int s = 2; s <= 8; s++) begin
			p_s[s] <= p_s[s-1];
		end
		for (int s = 3; s <= 8; s++) begin
			e_s[s] <= e_s[s-1];
		end
	end

	// first multiplier level: cross terms, vertex dots, edge lengths
	for (genvar i = 0; i < 3; i++) begin : g_l1
		stst_mul #(.AW(C+1), .BW(C+1)) u_mca (.clk(clk),
			.a(e_s[2][2][(i+1)%3]), .b(e_s[2][0][(i+2)%3]), .p(mca[i]));
		stst_mul #(.AW(C+1), .BW(C+1)) u_mcb (.clk(clk),
			.a(e_s[2][2][(i+2)%3]), .b(e_s[2][0][(i+1)%3]), .p(mcb[i]));
		for (genvar k = 0; k < 3; k++) begin : g_k
			stst_mul #(.AW(C), .BW(C)) u_sq (.clk(clk),
				.a(p_s[2][k][i]), .b(p_s[2][k][i]), .p(msq[k][i]));
			stst_mul #(.AW(C), .BW(C)) u_x (.clk(clk),
				.a(p_s[2][k][i]), .b(p_s[2][(k+1)%3][i]), .p(mx[k][i]));
			stst_mul #(.AW(C+1), .BW(C+1)) u_ee (.clk(clk),
				.a(e_s[2][k][i]), .b(e_s[2][k][i]), .p(mee[k][i]));
		end
	end

	// vertex regions: nearest vertex beyond the radius
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vtx_c[k] = (sq_s7[k] > rr_sg) && (x_s7[k] > sq_s7[k])
				&& (x_s7[(k+2)%3] > sq_s7[k]);
		end
	end

	// s7: sum first-level products; s8: edge offsets and vertex tests
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			v_s7[k]  <= (2*C+3)'(mca[k]) - (2*C+3)'(mcb[k]);
			sq_s7[k] <= (2*C+2)'(msq[k][0]) + (2*C+2)'(msq[k][1]) + (2*C+2)'(msq[k][2]);
			x_s7[k]  <= (2*C+2)'(mx[k][0]) + (2*C+2)'(mx[k][1]) + (2*C+2)'(mx[k][2]);
			ee_s[7][k] <= (2*C+4)'(mee[k][0]) + (2*C+4)'(mee[k][1])
				+ (2*C+4)'(mee[k][2]);
			d_s8[k]  <= (2*C+3)'(x_s7[k]) - (2*C+3)'(sq_s7[k]);
		end
		v_s8     <= v_s7;
		vtx_s[8] <= vtx_c;
		for (int s = 9; s <= 18; s++) begin
			vtx_s[s] <= vtx_s[s-1];
		end
		for (int s = 8; s <= 13; s++) begin
			ee_s[s] <= ee_s[s-1];
		end
	end

	// second multiplier level: plane distance, normal length, edge projections
	for (genvar i = 0; i < 3; i++) begin : g_l2
		stst_mul #(.AW(C), .BW(2*C+3)) u_av (.clk(clk),
			.a(p_s[8][0][i]), .b(v_s8[i]), .p(mav[i]));
		stst_mul #(.AW(2*C+3), .BW(2*C+3)) u_vv (.clk(clk),
			.a(v_s8[i]), .b(v_s8[i]), .p(mvv[i]));
		stst_mul #(.AW(2*R+1), .BW(2*C+4)) u_rree (.clk(clk),
			.a(rr_sg), .b(ee_s[8][i]), .p(mrree[i]));
		for (genvar k = 0; k < 3; k++) begin : g_k
			stst_mul #(.AW(C), .BW(2*C+4)) u_pee (.clk(clk),
				.a(p_s[8][k][i]), .b(ee_s[8][k]), .p(mpee[k][i]));
			stst_mul #(.AW(C+1), .BW(2*C+3)) u_ed (.clk(clk),
				.a(e_s[8][k][i]), .b(d_s8[k]), .p(med[k][i]));
			stst_mul #(.AW(C), .BW(2*C+4)) u_oee (.clk(clk),
				.a(p_s[8][(k+2)%3][i]), .b(ee_s[8][k]), .p(moee[k][i]));
		end
	end

	// s13: plane terms, nearest edge point and its offset to the far vertex
	always_ff @(posedge clk) begin
		f_s13 <= (3*C+5)'(mav[0]) + (3*C+5)'(mav[1]) + (3*C+5)'(mav[2]);
		e_s13 <= (4*C+8)'(mvv[0]) + (4*C+8)'(mvv[1]) + (4*C+8)'(mvv[2]);
		for (int k = 0; k < 3; k++) begin
			rree_s13[k] <= mrree[k];
			for (int i = 0; i < 3; i++) begin
				q_s13[k][i]  <= (3*C+5)'(mpee[k][i]) - (3*C+5)'(med[k][i]);
				qo_s13[k][i] <= (3*C+6)'(moee[k][i]) - (3*C+6)'(mpee[k][i])
					+ (3*C+6)'(med[k][i]);
			end
		end
	end

	// third multiplier level: squared distances against scaled radius
	stst_mul #(.AW(3*C+5), .BW(3*C+5)) u_ff (.clk(clk),
		.a(f_s13), .b(f_s13), .p(mff));
	stst_mul #(.AW(2*R+1), .BW(4*C+8)) u_re (.clk(clk),
		.a(rr_sg), .b(e_s13), .p(mre));
	for (genvar k = 0; k < 3; k++) begin : g_l3
		stst_mul #(.AW(2*R+2*C+5), .BW(2*C+4)) u_r3 (.clk(clk),
			.a(rree_s13[k]), .b(ee_s[13][k]), .p(mr3[k]));
		for (genvar i = 0; i < 3; i++) begin : g_i
			stst_mul #(.AW(3*C+5), .BW(3*C+5)) u_qq (.clk(clk),
				.a(q_s13[k][i]), .b(q_s13[k][i]), .p(mqq[k][i]));
			stst_mul #(.AW(3*C+5), .BW(3*C+6)) u_qqo (.clk(clk),
				.a(q_s13[k][i]), .b(qo_s13[k][i]), .p(mqqo[k][i]));
		end
	end

	// edge regions: beyond the radius and facing away from the far vertex
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			edge_c[k] = (qq_s18[k] > r3_s18[k]) && (qqo_s18[k] > CW'(0));
		end
	end

	// s18: plane test and edge sums; s19: merge all seven axes
	always_ff @(posedge clk) begin
		plane_s18 <= mff > mre;
		for (int k = 0; k < 3; k++) begin
			qq_s18[k]  <= CW'(mqq[k][0]) + CW'(mqq[k][1]) + CW'(mqq[k][2]);
			qqo_s18[k] <= CW'(mqqo[k][0]) + CW'(mqqo[k][1]) + CW'(mqqo[k][2]);
			r3_s18[k]  <= mr3[k];
		end
		sep_s19 <= plane_s18 || (|vtx_s[18]) || (|edge_c);
	end

	`ASSERT_CLK(a_lat, clk, arst_n, start |-> ##19 done, "request did not complete in 19 cycles")
	`ASSERT_CLK(a_src, clk, arst_n, done |-> $past(start, 19), "result without a request")
endmodule
`default_nettype wire

// ===== sim/sphere_triangle_separation_test_core_tb.sv =====
// Self-checking bench for the sphere/triangle separation test core.
// Drives coordinate requests and radius writes, predicts the separation bit.
// Depends on stst_pkg and sphere_triangle_separation_test_core.
`timescale 1ns / 100ps
`default_nettype none
module sphere_triangle_separation_test_core_tb;
	import stst_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int LAT = 19;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic signed [255:0] wide_t;
	typedef struct packed {
		coord_t ax, ay, az, bx, by, bz, cx, cy, cz, sx, sy, sz;
	} tri_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, separated;
	tri_req_t req = '0;
	logic radius_we = 1'b0;
	logic [RADIUS_BITS-1:0] radius_wdata = '0;

	tri_req_t pending_q[$];
	logic sep_expect_q[$];
	logic [RADIUS_BITS-1:0] model_radius = '0;
	int mismatches = 0;
	int idle_left = 0;
	bit feed_on = 1'b0;

	always #5 clk = ~clk;

	sphere_triangle_separation_test_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vert0_x(req.ax), .vert0_y(req.ay), .vert0_z(req.az),
		.vert1_x(req.bx), .vert1_y(req.by), .vert1_z(req.bz),
		.vert2_x(req.cx), .vert2_y(req.cy), .vert2_z(req.cz),
		.center_x(req.sx), .center_y(req.sy), .center_z(req.sz),
		.sphere_radius_we(radius_we), .sphere_radius_wdata(radius_wdata),
		.done(done), .separated(separated)
	);

	function automatic wide_t dot3(wide_t a0, wide_t a1, wide_t a2,
			wide_t b0, wide_t b1, wide_t b2);
		return a0 * b0 + a1 * b1 + a2 * b2;
	endfunction

	// vertex region: P nearest vertex and outside the radius
	function automatic bit corner_clear(wide_t pp, wide_t p1, wide_t p2, wide_t rr);
		return pp > rr && p1 > pp && p2 > pp;
	endfunction

	// edge region from P along E, opposite vertex O
	function automatic bit edge_clear(wide_t p[3], wide_t e[3], wide_t o[3],
			wide_t d, wide_t rr);
		wide_t ee, qq, qqo;
		wide_t q[3], qo[3];
		ee = dot3(e[0], e[1], e[2], e[0], e[1], e[2]);
		for (int i = 0; i < 3; i++) begin
			q[i] = p[i] * ee - e[i] * d;
			qo[i] = o[i] * ee - q[i];
		end
		qq = dot3(q[0], q[1], q[2], q[0], q[1], q[2]);
		qqo = dot3(q[0], q[1], q[2], qo[0], qo[1], qo[2]);
		return qq > rr * ee * ee && qqo > 0;
	endfunction

	function automatic logic predict_separation(tri_req_t t, logic [RADIUS_BITS-1:0] rad);
		wide_t a[3], b[3], c[3], ab_e[3], bc_e[3], ca_e[3], u[3], w[3], n[3];
		wide_t rr, f, nn, aa, ab, ac, bb, bc, cc;
		bit sep;
		a[0] = wide_t'(t.ax) - wide_t'(t.sx);
		a[1] = wide_t'(t.ay) - wide_t'(t.sy);
		a[2] = wide_t'(t.az) - wide_t'(t.sz);
		b[0] = wide_t'(t.bx) - wide_t'(t.sx);
		b[1] = wide_t'(t.by) - wide_t'(t.sy);
		b[2] = wide_t'(t.bz) - wide_t'(t.sz);
		c[0] = wide_t'(t.cx) - wide_t'(t.sx);
		c[1] = wide_t'(t.cy) - wide_t'(t.sy);
		c[2] = wide_t'(t.cz) - wide_t'(t.sz);
		rr = wide_t'({1'b0, rad}) * wide_t'({1'b0, rad});
		for (int i = 0; i < 3; i++) begin
			u[i] = b[i] - a[i];
			w[i] = c[i] - a[i];
			ab_e[i] = b[i] - a[i];
			bc_e[i] = c[i] - b[i];
			ca_e[i] = a[i] - c[i];
		end
		n[0] = u[1] * w[2] - u[2] * w[1];
		n[1] = u[2] * w[0] - u[0] * w[2];
		n[2] = u[0] * w[1] - u[1] * w[0];
		f = dot3(a[0], a[1], a[2], n[0], n[1], n[2]);
		nn = dot3(n[0], n[1], n[2], n[0], n[1], n[2]);
		sep = f * f > rr * nn;
		aa = dot3(a[0], a[1], a[2], a[0], a[1], a[2]);
		ab = dot3(a[0], a[1], a[2], b[0], b[1], b[2]);
		ac = dot3(a[0], a[1], a[2], c[0], c[1], c[2]);
		bb = dot3(b[0], b[1], b[2], b[0], b[1], b[2]);
		bc = dot3(b[0], b[1], b[2], c[0], c[1], c[2]);
		cc = dot3(c[0], c[1], c[2], c[0], c[1], c[2]);
		sep |= corner_clear(aa, ab, ac, rr);
		sep |= corner_clear(bb, ab, bc, rr);
		sep |= corner_clear(cc, ac, bc, rr);
		sep |= edge_clear(a, ab_e, c, ab - aa, rr);
		sep |= edge_clear(b, bc_e, a, bc - bb, rr);
		sep |= edge_clear(c, ca_e, b, ac - cc, rr);
		return sep;
	endfunction

	// driver: pop one request per accepted edge, random gaps
	always @(posedge clk) begin
		if (start && !busy) begin
			sep_expect_q.push_back(predict_separation(req, model_radius));
		end
		if (start && busy) begin
			// hold the request until taken
		end else if (idle_left > 0) begin
			idle_left <= idle_left - 1;
			start <= 1'b0;
		end else if (feed_on && pending_q.size() > 0) begin
			req <= pending_q.pop_front();
			start <= 1'b1;
			if ($urandom_range(99) < 25)
				idle_left <= ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(3);
		end else begin
			start <= 1'b0;
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (sep_expect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result separated=%0b", separated);
			end else begin
				logic exp_sep;
				exp_sep = sep_expect_q.pop_front();
				if (separated !== exp_sep) begin
					mismatches++;
					if (mismatches <= 10)
						$display("separated mismatch: expected %0b got %0b", exp_sep, separated);
				end
			end
		end
	end

	function automatic coord_t pick_coord(int spread);
		case ($urandom_range(9))
			0: return coord_t'(16'sh7fff);
			1: return coord_t'(16'sh8000);
			2, 3: return coord_t'($urandom);
			default: return coord_t'($signed($urandom_range(2 * spread)) - spread);
		endcase
	endfunction

	function automatic tri_req_t make_req(int spread);
		tri_req_t t;
		t.ax = pick_coord(spread); t.ay = pick_coord(spread); t.az = pick_coord(spread);
		t.bx = pick_coord(spread); t.by = pick_coord(spread); t.bz = pick_coord(spread);
		t.cx = pick_coord(spread); t.cy = pick_coord(spread); t.cz = pick_coord(spread);
		t.sx = pick_coord(spread); t.sy = pick_coord(spread); t.sz = pick_coord(spread);
		// occasionally collapse vertices into a degenerate triangle
		if ($urandom_range(15) == 0) {t.bx, t.by, t.bz} = {t.ax, t.ay, t.az};
		if ($urandom_range(15) == 0) begin
			t.cx = t.bx + (t.bx - t.ax); t.cy = t.by + (t.by - t.ay);
			t.cz = t.bz + (t.bz - t.az);
		end
		return t;
	endfunction

	task automatic run_batch();
		feed_on = 1'b1;
		while (pending_q.size() != 0 || start) @(posedge clk);
		@(posedge clk);
		while (sep_expect_q.size() != 0) @(posedge clk);
		feed_on = 1'b0;
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic write_radius(logic [RADIUS_BITS-1:0] r);
		@(posedge clk);
		radius_we <= 1'b1;
		radius_wdata <= r;
		model_radius = r;
		@(posedge clk);
		radius_we <= 1'b0;
	endtask

	initial begin
		tri_req_t t;
		logic [RADIUS_BITS-1:0] radii[6];
		radii = '{15'd0, 15'h7fff, 15'd1, 15'd100, 15'd5000, 15'd0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset radius, extremes, degenerate, touching
		t = '0; pending_q.push_back(t);
		t = '{default: coord_t'(16'sh7fff)}; pending_q.push_back(t);
		t = '{default: coord_t'(16'sh8000)}; pending_q.push_back(t);
		t = '0; t.ax = 16'sh7fff; t.by = 16'sh8000; t.cz = 16'sh7fff;
		t.sx = 16'sh8000; pending_q.push_back(t);
		t = '0; t.ax = 10; t.bx = 20; t.cx = 30; pending_q.push_back(t);
		t = '0; t.ax = 5; t.ay = 5; t.bx = 5; t.by = 5; t.cx = 5; t.cy = 5;
		pending_q.push_back(t);
		run_batch();
		write_radius(15'd10);
		// touching: plane at distance 10, vertex at 10, edge at 10
		t = '0; t.ax = -5; t.ay = -5; t.az = 10; t.bx = 5; t.by = -5; t.bz = 10;
		t.cx = 0; t.cy = 5; t.cz = 10; pending_q.push_back(t);
		t = '0; t.ax = 10; t.bx = 20; t.by = 5; t.cx = 20; t.cy = -5; pending_q.push_back(t);
		t = '0; t.ax = 10; t.ay = -5; t.bx = 10; t.by = 5; t.cx = 20; pending_q.push_back(t);
		t = '0; t.ax = 11; t.ay = -5; t.bx = 11; t.by = 5; t.cx = 20; pending_q.push_back(t);
		t = '0; t.sx = 16'sh7fff; t.ax = 16'sh8000; t.bx = 16'sh8000; t.by = 1;
		t.cx = 16'sh8000; t.cz = 1; pending_q.push_back(t);
		run_batch();

		// random phases across radius settings
		foreach (radii[k]) begin
			write_radius(radii[k]);
			repeat (250) pending_q.push_back(make_req((k % 2) ? 32767 : 400));
			run_batch();
		end
		repeat (LAT + 4) @(posedge clk);
		if (mismatches == 0 && sep_expect_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/stst_pkg.sv
rtl/stst_mul.sv
rtl/sphere_triangle_separation_test_core.sv
sim/sphere_triangle_separation_test_core_tb.sv
